[src/chs_pkg.sv]
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants of the chained hash set
// Bucket count, chain depth, derived widths and the reciprocal for the
// division-method hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chs_pkg;

  localparam int unsigned BUCKETS     = 701;
  localparam int unsigned CHAIN_DEPTH = 8;

  localparam int unsigned KEY_W     = 31;
  localparam int unsigned BUCKET_W  = $clog2(BUCKETS);
  localparam int unsigned SLOT_W    = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int unsigned COUNT_W   = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned ENTRIES   = BUCKETS * CHAIN_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(ENTRIES);

  // Exact floor(key / BUCKETS) as (key * RECIP) >> HASH_SHIFT for every key.
  localparam int unsigned HASH_SHIFT = KEY_W + BUCKET_W;
  localparam int unsigned RECIP_W    = 32;
  localparam longint unsigned RECIP  =
    ((64'd1 << HASH_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam int unsigned PROD_W     = KEY_W + RECIP_W;
  localparam int unsigned QUOT_W     = PROD_W - HASH_SHIFT;
  localparam int unsigned QM_W       = QUOT_W + BUCKET_W;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_e;

endpackage

[src/chs_if.sv]
// ----------------------------------------------------------------------------
// chs_req_if / chs_rsp_if: request and response channels
// Valid/ready channels carrying one operation word and one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface chs_req_if;
  logic          valid;
  logic          ready;
  chs_pkg::kind_e kind;
  chs_pkg::key_t key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface chs_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic overflow;

  modport source (output valid, output found, output overflow, input ready);
  modport sink   (input valid, input found, input overflow, output ready);
endinterface

[src/chained_hash_set.sv]
// ----------------------------------------------------------------------------
// chained_hash_set_core: hash set with chained buckets
// Insert and search of 31-bit keys, bucket = key mod 701, eight slots each.
// ----------------------------------------------------------------------------
//
// Usage:
//   req_i carries one word per operation: kind (insert or search) and key.
//   rsp_o returns exactly one word per operation: found for a search,
//   overflow for an insert into a full chain; the other flag is zero.
//   An operation is taken only while req_i.ready is high; the block works
//   on one operation at a time.
//   Hashing by reciprocal multiply runs through the multiply, fold and
//   remainder states, then the bucket count is read. An insert then stores
//   its key or flags overflow; a search walks its chain one stored entry per
//   cycle through the single read port of the chain store and compare unit.
//   The next word can be taken in the cycle after the result loads.
//   After reset the bucket counters are cleared one per cycle: req_i.ready
//   stays low until all 701 of them are cleared.
//   The result sits in an output register; a new operation is accepted
//   while it waits, and a finished result is held in the block until
//   rsp_o.ready frees the register.
//
`timescale 1ns / 1ps

module chained_hash_set_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  chs_req_if.sink   req_i,
  chs_rsp_if.source rsp_o
);
  import chs_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_FOLD  = 4'd3;
  localparam logic [3:0] S_REM   = 4'd4;
  localparam logic [3:0] S_CRD   = 4'd5;
  localparam logic [3:0] S_CNT   = 4'd6;
  localparam logic [3:0] S_WALK  = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

  logic [3:0]        state_q, state_d;
  logic [BUCKET_W-1:0] clr_idx_q, clr_idx_d;
  kind_e             kind_q;
  key_t              key_q;
  logic [QUOT_W-1:0] quot_q;
  logic [QM_W-1:0]   qm_q;
  bucket_t           bucket_q;
  count_t            cnt_q;
  count_t            idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              res_found_q, res_found_d;
  logic              res_ovf_q, res_ovf_d;
  logic              rsp_valid_q;
  logic              rsp_found_q;
  logic              rsp_ovf_q;

  logic [PROD_W-1:0] prod;
  logic [QM_W-1:0]   rem_full;
  logic              accept;
  logic              rsp_load;

  logic              cnt_we;
  bucket_t           cnt_waddr;
  count_t            cnt_wdata;
  logic              cnt_re;
  logic              st_we;
  logic              st_re;
  addr_t             st_addr;
  key_t              st_rdata_q;

  count_t            cnt_mem [BUCKETS];
  key_t              st_mem  [ENTRIES];

  assign accept   = req_i.valid && req_i.ready;
  assign prod     = PROD_W'(key_q) * PROD_W'(RECIP_V);
  assign rem_full = QM_W'(key_q) - qm_q;
  assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp_o.ready);

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.found    = rsp_found_q;
  assign rsp_o.overflow = rsp_ovf_q;

  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    res_found_d = res_found_q;
    res_ovf_d   = res_ovf_q;
    cnt_we      = 1'b0;
    cnt_waddr   = bucket_q;
    cnt_wdata   = '0;
    cnt_re      = 1'b0;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_addr     = ADDR_W'(bucket_q) * ADDR_W'(CHAIN_DEPTH) + ADDR_W'(idx_q[SLOT_W-1:0]);
    case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx_q;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == BUCKET_W'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_MUL;
        end
      end
      S_MUL:  state_d = S_FOLD;
      S_FOLD: state_d = S_REM;
      S_REM:  state_d = S_CRD;
      S_CRD: begin
        cnt_re  = 1'b1;
        state_d = S_CNT;
      end
      S_CNT: begin
        res_found_d = 1'b0;
        res_ovf_d   = 1'b0;
        idx_d       = '0;
        pend_d      = 1'b0;
        if (kind_q == KIND_INSERT) begin
          state_d = S_RESP;
          if (cnt_q >= COUNT_W'(CHAIN_DEPTH)) begin
            res_ovf_d = 1'b1;
          end else begin
            st_we     = 1'b1;
            st_addr   = ADDR_W'(bucket_q) * ADDR_W'(CHAIN_DEPTH)
                        + ADDR_W'(cnt_q[SLOT_W-1:0]);
            cnt_we    = 1'b1;
            cnt_wdata = cnt_q + 1'b1;
          end
        end else begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (pend_q && (st_rdata_q == key_q)) begin
          res_found_d = 1'b1;
          state_d     = S_RESP;
        end else if (idx_q < cnt_q) begin
          st_re  = 1'b1;
          idx_d  = idx_q + 1'b1;
          pend_d = 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_idx_q   <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      res_found_q <= 1'b0;
      res_ovf_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      res_found_q <= res_found_d;
      res_ovf_q   <= res_ovf_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_i.kind;
      key_q  <= req_i.key;
    end
    if (state_q == S_MUL) begin
      quot_q <= prod[PROD_W-1:HASH_SHIFT];
    end
    if (state_q == S_FOLD) begin
      qm_q <= QM_W'(quot_q) * QM_W'(BUCKETS);
    end
    if (state_q == S_REM) begin
      bucket_q <= rem_full[BUCKET_W-1:0];
    end
    if (rsp_load) begin
      rsp_found_q <= res_found_q;
      rsp_ovf_q   <= res_ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[bucket_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_addr] <= key_q;
    end
    if (st_re) begin
      st_rdata_q <= st_mem[st_addr];
    end
  end

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(rsp_found_q && rsp_ovf_q))
    else $error("found and overflow both set");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CNT) |-> (cnt_q <= COUNT_W'(CHAIN_DEPTH)))
    else $error("chain count above depth");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (idx_q <= cnt_q))
    else $error("chain walk past count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (!req_i.ready && (state_q == S_MUL)))
    else $error("ready after accept");

  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRD) |-> (bucket_q < BUCKET_W'(BUCKETS)))
    else $error("bucket out of range");

endmodule
